>>> rtl/tsif_pkg.sv
package tsif_pkg;

    localparam int unsigned NODE_W    = 8;
    localparam int unsigned FEAT_W    = 6;
    localparam int unsigned MASK_W    = 64;
    localparam int unsigned FCOUNT_W  = 7;
    localparam int unsigned CCOUNT_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONSTRAINT_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONSTRAINT_SET0  = 3'd2;

    localparam logic [FCOUNT_W-1:0] FEATURE_COUNT_RESET    = 7'd64;
    localparam logic [CCOUNT_W-1:0] CONSTRAINT_COUNT_RESET = 3'd0;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0] parent_node;
        logic [FEAT_W-1:0] split_feature;
        logic [NODE_W-1:0] left_child;
        logic [NODE_W-1:0] right_child;
    } s_word_t;

    typedef struct packed {
        logic [MASK_W-1:0] allowed_mask;
        logic [MASK_W-1:0] history_mask;
        logic              status;
    } m_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

endpackage

>>> rtl/tree_split_interaction_filter_unit.sv
// an accepted word is read in ST_READ and its result loaded into m_data in ST_WRITE once
//   the output is free, when a new word may also be accepted; the single write port of the
//   history memory takes the left child write in ST_READ and the right child in ST_WRITE
// reset: synchronous active-low aresetn restores the register defaults, marks
//   node 0 as an empty history and empties the output register; the memory is not cleared
module tree_split_interaction_filter_unit
    import tsif_pkg::*;
#(
    parameter int unsigned MAX_NODES       = 256,
    parameter int unsigned MAX_FEATURES    = 64,
    parameter int unsigned NUM_CONSTRAINTS = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  s_word_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output m_word_t               m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [MASK_W-1:0]     cfg_wdata
);

    localparam int unsigned ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [MASK_W-1:0] WMASK =
        (MAX_FEATURES >= MASK_W) ? {MASK_W{1'b1}}
                                 : ((64'd1 << MAX_FEATURES) - 64'd1);
    localparam logic [CCOUNT_W-1:0] CC_MAX = CCOUNT_W'(NUM_CONSTRAINTS);
    localparam logic [FCOUNT_W-1:0] FC_MAX = FCOUNT_W'(MAX_FEATURES);

    // configuration
    logic [FCOUNT_W-1:0] feature_count_reg;
    logic [CCOUNT_W-1:0] constraint_count_reg;
    logic [MASK_W-1:0]   cset_reg [NUM_CONSTRAINTS];

    // control
    state_t              state_reg, state_next;
    logic                node0_valid_reg;
    logic                m_valid_reg;
    m_word_t             m_data_reg;

    // item in flight
    logic [FEAT_W-1:0]   feat_reg;
    logic [ADDR_W-1:0]   left_reg;
    logic [ADDR_W-1:0]   right_reg;
    logic                err_reg;
    logic                fwd_reg;
    logic                zero_reg;
    logic [MASK_W-1:0]   hist_reg;

    // history memory
    logic [MASK_W-1:0]   hist_mem [MAX_NODES];
    logic [MASK_W-1:0]   rd_data_reg;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [MASK_W-1:0]   wr_data;

    logic                accept;
    logic                out_free;
    logic                load_out;
    logic                in_err;
    logic [ADDR_W-1:0]   rd_addr;
    logic [MASK_W-1:0]   base_hist;
    logic [MASK_W-1:0]   hist_now;
    logic [MASK_W-1:0]   allowed;
    logic [MASK_W-1:0]   fc_mask;
    logic [FCOUNT_W-1:0] fc_sat;
    logic [CCOUNT_W-1:0] cc_sat;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_addr  = ADDR_W'(s_data.parent_node);
    assign in_err   = (32'(s_data.parent_node) >= MAX_NODES)
                   || (32'(s_data.left_child)  >= MAX_NODES)
                   || (32'(s_data.right_child) >= MAX_NODES);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feature_count_reg    <= FEATURE_COUNT_RESET;
            constraint_count_reg <= CONSTRAINT_COUNT_RESET;
            for (int i = 0; i < NUM_CONSTRAINTS; i++) begin
                cset_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_index == REG_FEATURE_COUNT) begin
                feature_count_reg <= cfg_wdata[FCOUNT_W-1:0];
            end else if (cfg_index == REG_CONSTRAINT_COUNT) begin
                constraint_count_reg <= cfg_wdata[CCOUNT_W-1:0];
            end else begin
                for (int i = 0; i < NUM_CONSTRAINTS; i++) begin
                    if (32'(cfg_index) == 32'(REG_CONSTRAINT_SET0) + 32'(i)) begin
                        cset_reg[i] <= cfg_wdata;
                    end
                end
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = accept ? ST_READ : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_ready  = 1'b0;
        load_out = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = left_reg;
        wr_data  = hist_now;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_READ: begin
                wr_en   = !err_reg;
                wr_addr = left_reg;
                wr_data = hist_now;
            end
            ST_WRITE: begin
                s_ready  = out_free;
                load_out = out_free;
                wr_en    = !err_reg;
                wr_addr  = right_reg;
                wr_data  = hist_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // parent history with forwarding of the right child write that overlaps the read
    always_comb begin
        if (fwd_reg) begin
            base_hist = hist_reg;
        end else if (zero_reg) begin
            base_hist = '0;
        end else begin
            base_hist = rd_data_reg;
        end
        hist_now = base_hist & WMASK;
        if (32'(feat_reg) < MAX_FEATURES) begin
            hist_now = hist_now | (64'd1 << feat_reg);
        end
    end

    // allowed mask from history and constraint sets, or feature count if no set enabled
    always_comb begin
        fc_sat  = (feature_count_reg > FC_MAX) ? FC_MAX : feature_count_reg;
        cc_sat  = (constraint_count_reg > CC_MAX) ? CC_MAX : constraint_count_reg;
        for (int b = 0; b < MASK_W; b++) begin
            fc_mask[b] = (FCOUNT_W'(b) < fc_sat);
        end
        allowed = hist_reg;
        for (int i = 0; i < NUM_CONSTRAINTS; i++) begin
            if ((CCOUNT_W'(i) < cc_sat)
                && ((hist_reg & ~(cset_reg[i] & WMASK)) == '0)) begin
                allowed = allowed | (cset_reg[i] & WMASK);
            end
        end
        if (cc_sat == '0) begin
            allowed = fc_mask & WMASK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            node0_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (wr_en && (wr_addr == '0)) begin
                node0_valid_reg <= 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            feat_reg  <= s_data.split_feature;
            left_reg  <= ADDR_W'(s_data.left_child);
            right_reg <= ADDR_W'(s_data.right_child);
            err_reg   <= in_err;
            fwd_reg   <= (state_reg == ST_WRITE) && !err_reg && (rd_addr == right_reg);
            zero_reg  <= (rd_addr == '0) && !node0_valid_reg;
        end
        if (state_reg == ST_READ) begin
            hist_reg <= hist_now;
        end
        if (load_out) begin
            if (err_reg) begin
                m_data_reg.allowed_mask <= '0;
                m_data_reg.history_mask <= '0;
                m_data_reg.status       <= STATUS_BAD_INDEX;
            end else begin
                m_data_reg.allowed_mask <= allowed;
                m_data_reg.history_mask <= hist_reg;
                m_data_reg.status       <= STATUS_OK;
            end
        end
    end

    // history memory, one read and one write port
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= hist_mem[rd_addr];
        end
        if (wr_en) begin
            hist_mem[wr_addr] <= wr_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/tsif_checker.sv
module tsif_checker
    import tsif_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input m_word_t m_data
);

    // a result word waiting for the sink holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // a bad node index returns empty masks
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_BAD_INDEX) |->
            (m_data.allowed_mask == '0) && (m_data.history_mask == '0))
        else $error("error word with nonzero masks");

    // after an accepted word the unit is in ST_READ and not ready, so no two words back to back
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted in consecutive cycles");

    // output empty after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind tree_split_interaction_filter_unit tsif_checker u_tsif_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> tb/tree_split_interaction_filter_unit_test.sv
module tree_split_interaction_filter_unit_test;
    import tsif_pkg::*;

    localparam int unsigned NODE_COUNT   = 256;
    localparam int unsigned FEAT_COUNT   = 64;
    localparam int unsigned SET_COUNT    = 6;
    localparam int unsigned PHASE_ITEMS  = 225;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE_CYCLES = 6;

    class split_scoreboard;
        logic [MASK_W-1:0]   hist_table [NODE_COUNT];
        logic [FCOUNT_W-1:0] feat_count;
        logic [CCOUNT_W-1:0] set_count;
        logic [MASK_W-1:0]   csets [SET_COUNT];
        m_word_t             waiting_q [$];
        int unsigned         n_checked;
        int unsigned         n_bad;
        int unsigned         deepest;

        function new();
            foreach (hist_table[i]) hist_table[i] = '0;
            foreach (csets[i]) csets[i] = '0;
            feat_count = FEATURE_COUNT_RESET;
            set_count  = CONSTRAINT_COUNT_RESET;
            n_checked  = 0;
            n_bad      = 0;
            deepest    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] val);
            if (idx == REG_FEATURE_COUNT)
                feat_count = val[FCOUNT_W-1:0];
            else if (idx == REG_CONSTRAINT_COUNT)
                set_count = val[CCOUNT_W-1:0];
            else if (idx >= REG_CONSTRAINT_SET0 && idx < REG_CONSTRAINT_SET0 + SET_COUNT)
                csets[idx - REG_CONSTRAINT_SET0] = val;
        endfunction

        function int unsigned pending();
            return waiting_q.size();
        endfunction

        // predicted child history and allowed mask for one accepted split word
        function void note_split(s_word_t w);
            m_word_t           exp;
            logic [MASK_W-1:0] h;
            logic [MASK_W-1:0] allowed;
            int unsigned       n;
            int unsigned       f;
            if (int'(w.parent_node) >= NODE_COUNT || int'(w.left_child) >= NODE_COUNT ||
                int'(w.right_child) >= NODE_COUNT) begin
                exp.allowed_mask = '0;
                exp.history_mask = '0;
                exp.status       = STATUS_BAD_INDEX;
                waiting_q.push_back(exp);
                return;
            end
            h = hist_table[w.parent_node];
            if (int'(w.split_feature) < FEAT_COUNT)
                h[w.split_feature] = 1'b1;
            hist_table[w.left_child]  = h;
            hist_table[w.right_child] = h;
            if ($countones(h) > deepest)
                deepest = $countones(h);
            n = (set_count > SET_COUNT) ? SET_COUNT : set_count;
            if (n == 0) begin
                f = (feat_count > FEAT_COUNT) ? FEAT_COUNT : feat_count;
                allowed = (f >= FEAT_COUNT) ? '1 : ((64'd1 << f) - 64'd1);
            end else begin
                allowed = h;
                for (int i = 0; i < n; i++) begin
                    if ((h & ~csets[i]) == '0)
                        allowed |= csets[i];
                end
            end
            exp.allowed_mask = allowed;
            exp.history_mask = h;
            exp.status       = STATUS_OK;
            waiting_q.push_back(exp);
        endfunction

        function void check_result(m_word_t got);
            m_word_t exp;
            if (waiting_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result word: allowed %h history %h status %0b",
                             got.allowed_mask, got.history_mask, got.status);
                return;
            end
            exp = waiting_q.pop_front();
            n_checked++;
            if (got.allowed_mask !== exp.allowed_mask ||
                got.history_mask !== exp.history_mask ||
                got.status !== exp.status) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("mismatch on result %0d: allowed %h/%h history %h/%h status %0b/%0b",
                             n_checked, exp.allowed_mask, got.allowed_mask,
                             exp.history_mask, got.history_mask, exp.status, got.status);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    s_word_t              s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    m_word_t              m_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MASK_W-1:0]    cfg_wdata = '0;

    split_scoreboard      sb;
    logic [MASK_W-1:0]    cset_plan [SET_COUNT];
    logic [MASK_W-1:0]    focus_mask = '0;
    bit                   node_seen [NODE_COUNT];
    logic [NODE_W-1:0]    seen_list [$];
    logic [NODE_W-1:0]    last_child = '0;
    bit                   tx_idle_on = 1'b1;
    bit                   rx_idle_on = 1'b1;
    int unsigned          hold_req = 0;
    int unsigned          n_sent = 0;
    int unsigned          n_settings = 0;
    int unsigned          cycle_count = 0;

    tree_split_interaction_filter_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** tree_split_interaction_filter_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_split(s_data);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        int unsigned n;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req != 0) begin
                n = hold_req;
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            stall = rx_idle_on ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if ($urandom_range(0, 39) == 0)
                rx_idle_on = !rx_idle_on;
        end
    end

    task automatic send_split(input s_word_t w);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        if (!node_seen[w.left_child]) begin
            node_seen[w.left_child] = 1'b1;
            seen_list.push_back(w.left_child);
        end
        if (!node_seen[w.right_child]) begin
            node_seen[w.right_child] = 1'b1;
            seen_list.push_back(w.right_child);
        end
        last_child = w.left_child;
        n_sent++;
        if ($urandom_range(0, 49) == 0)
            tx_idle_on = !tx_idle_on;
    endtask

    task automatic split_at(input int p, input int f, input int l, input int r);
        s_word_t w;
        w.parent_node   = NODE_W'(p);
        w.split_feature = FEAT_W'(f);
        w.left_child    = NODE_W'(l);
        w.right_child   = NODE_W'(r);
        send_split(w);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic apply_setting(input int unsigned fc, input int unsigned cc);
        int unsigned k;
        drain();
        cfg_write(REG_FEATURE_COUNT, MASK_W'(fc));
        cfg_write(REG_CONSTRAINT_COUNT, MASK_W'(cc));
        for (int i = 0; i < SET_COUNT; i++)
            cfg_write(CFG_IDX_W'(REG_CONSTRAINT_SET0 + i), cset_plan[i]);
        cfg_we <= 1'b0;
        k = (cc == 0) ? SET_COUNT : ((cc > SET_COUNT) ? SET_COUNT : cc);
        focus_mask = cset_plan[$urandom_range(0, k - 1)];
        n_settings++;
    endtask

    function automatic logic [MASK_W-1:0] rand_set();
        logic [MASK_W-1:0] v;
        int unsigned       lo;
        int unsigned       hi;
        v = '0;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = {$urandom, $urandom};
            3, 4: begin
                lo = $urandom_range(0, 63);
                hi = $urandom_range(lo, 63);
                for (int b = lo; b <= hi; b++) v[b] = 1'b1;
            end
            default: begin
                repeat ($urandom_range(1, 6)) v[$urandom_range(0, 63)] = 1'b1;
            end
        endcase
        return v;
    endfunction

    // parents only from nodes already written; chains keep histories growing
    function automatic s_word_t pick_split();
        s_word_t     w;
        int unsigned r;
        int unsigned f;
        r = $urandom_range(0, 99);
        if (r < 30)
            w.parent_node = last_child;
        else if (r < 42)
            w.parent_node = '0;
        else
            w.parent_node = seen_list[$urandom_range(0, seen_list.size() - 1)];
        if (focus_mask != '0 && $urandom_range(0, 1) == 1) begin
            do f = $urandom_range(0, 63); while (!focus_mask[f]);
        end else begin
            f = $urandom_range(0, 63);
        end
        w.split_feature = FEAT_W'(f);
        w.left_child    = NODE_W'($urandom_range(1, 255));
        r = $urandom_range(0, 99);
        if (r < 10)
            w.right_child = w.left_child;
        else if (r < 13)
            w.right_child = '0;
        else if (r < 18)
            w.right_child = w.parent_node;
        else
            w.right_child = NODE_W'($urandom_range(1, 255));
        return w;
    endfunction

    initial begin
        sb = new();
        foreach (node_seen[i]) node_seen[i] = 1'b0;
        node_seen[0] = 1'b1;
        seen_list.push_back('0);
        foreach (cset_plan[i]) cset_plan[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: filtering off, all 64 features allowed
        split_at(0, 0, 1, 2);
        split_at(1, 63, 3, 3);
        split_at(3, 63, 255, 4);
        split_at(255, 32, 254, 0);
        split_at(0, 5, 128, 127);
        split_at(128, 17, 170, 85);
        split_at(2, 62, 2, 200);

        // constraint count beyond six saturates
        cset_plan[0] = '1;
        cset_plan[1] = '0;
        cset_plan[2] = 64'h0000_0000_0000_000f;
        cset_plan[3] = 64'h0000_0000_0000_00f0;
        cset_plan[4] = 64'h8000_0000_0000_0000;
        cset_plan[5] = 64'h0000_ffff_0000_ffff;
        apply_setting(10, 7);
        split_at(1, 1, 10, 11);
        split_at(10, 3, 12, 13);
        split_at(12, 7, 14, 15);
        split_at(4, 63, 20, 21);
        split_at(170, 20, 22, 22);
        split_at(85, 4, 23, 24);
        split_at(23, 6, 25, 26);

        for (int ph = 0; ph < 8; ph++) begin
            foreach (cset_plan[i]) cset_plan[i] = rand_set();
            case (ph)
                0: apply_setting(64, 0);
                1: apply_setting(0, 0);
                2: apply_setting(127, 0);
                3: apply_setting($urandom_range(1, 63), 1);
                4: apply_setting(1, 6);
                5: apply_setting(64, 7);
                6: apply_setting($urandom_range(1, 63), $urandom_range(2, 5));
                default: apply_setting($urandom_range(65, 127), $urandom_range(1, 7));
            endcase
            if (ph == 4)
                hold_req = 300;
            repeat (PHASE_ITEMS) send_split(pick_split());
        end
        drain();

        $display("covered %0d split words over %0d register settings, %0d results checked",
                 n_sent, n_settings + 1, sb.n_checked);
        $display("deepest history %0d features, %0d nodes touched, %0d mismatches",
                 sb.deepest, seen_list.size(), sb.n_bad);
        if (sb.n_bad == 0 && sb.pending() == 0)
            $display("** tree_split_interaction_filter_unit: PASSED **");
        else
            $display("** tree_split_interaction_filter_unit: FAILED **");
        $finish;
    end

endmodule
